FILE: hdl/trd_pkg.sv
`timescale 1ns / 1ps

package trd_pkg;

  // Packet header layout
  localparam int unsigned MaxPacket   = 128;
  localparam int unsigned CountWidth  = $clog2(MaxPacket);       // 7
  localparam int unsigned RunWidth    = CountWidth + 1;          // 8

  // Configuration register widths and reset values
  localparam int unsigned BppWidth    = 3;
  localparam int unsigned PixCntWidth = 30;
  localparam int unsigned CfgWidth    = PixCntWidth;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [BppWidth-1:0]    BppReset    = BppWidth'(1);
  localparam logic [PixCntWidth-1:0] PixCntReset = PixCntWidth'(1);

  // Largest pixel, in bytes
  localparam logic [BppWidth-1:0]    BppMax      = BppWidth'(4);

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgBytesPerPixel = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgPixelCount    = 1'b1;

  typedef struct packed {
    logic [31:0]         pixel_value;
    logic [RunWidth-1:0] run_length;
    logic                image_done;
    logic                format_error;
  } res_t;

endpackage

FILE: hdl/trd_core.sv
`timescale 1ns / 1ps

module trd_core
  import trd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   beat_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  output logic                   res_valid_o,
  output res_t                   res_o
);

  logic [BppWidth-1:0]    bpp_q, bpp_d;
  logic [PixCntWidth-1:0] pix_cnt_q, pix_cnt_d;
  logic [PixCntWidth-1:0] pix_left_q, pix_left_d;
  logic                   in_body_q, in_body_d;
  logic                   repeat_q, repeat_d;
  logic [RunWidth-1:0]    pkt_left_q, pkt_left_d;
  logic [1:0]             byte_idx_q, byte_idx_d;
  logic [23:0]            accum_q, accum_d;
  logic                   err_q, err_d;

  logic [BppWidth-1:0]    size;
  logic [RunWidth-1:0]    count;
  logic [31:0]            merged;
  logic [RunWidth-1:0]    pkt_next;

  // Clamp pixel size to 1..4
  always_comb begin
    if (bpp_q == '0) begin
      size = BppWidth'(1);
    end else if (bpp_q > BppMax) begin
      size = BppMax;
    end else begin
      size = bpp_q;
    end
  end

  assign count  = RunWidth'(data_byte_i[CountWidth-1:0]) + RunWidth'(1);
  assign merged = {8'h00, accum_q} | (32'(data_byte_i) << {byte_idx_q, 3'b000});

  always_comb begin
    bpp_d       = bpp_q;
    pix_cnt_d   = pix_cnt_q;
    pix_left_d  = pix_left_q;
    in_body_d   = in_body_q;
    repeat_d    = repeat_q;
    pkt_left_d  = pkt_left_q;
    byte_idx_d  = byte_idx_q;
    accum_d     = accum_q;
    err_d       = err_q;
    pkt_next    = pkt_left_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (beat_i && !err_q) begin
      if (!in_body_q) begin
        if ({{(PixCntWidth-RunWidth){1'b0}}, count} > pix_left_q) begin
          err_d              = 1'b1;
          res_valid_o        = 1'b1;
          res_o.format_error = 1'b1;
        end else begin
          pix_left_d = pix_left_q - PixCntWidth'(count);
          repeat_d   = data_byte_i[CountWidth];
          pkt_left_d = count;
          in_body_d  = 1'b1;
          byte_idx_d = '0;
          accum_d    = '0;
        end
      end else if ({1'b0, byte_idx_q} + BppWidth'(1) >= size) begin
        res_valid_o       = 1'b1;
        res_o.pixel_value = merged;
        if (repeat_q) begin
          res_o.run_length = pkt_left_q;
          pkt_next         = '0;
        end else begin
          res_o.run_length = RunWidth'(1);
          pkt_next         = pkt_left_q - RunWidth'(1);
        end
        pkt_left_d = pkt_next;
        byte_idx_d = '0;
        accum_d    = '0;
        if (pkt_next == '0) begin
          in_body_d = 1'b0;
          if (pix_left_q == '0) begin
            res_o.image_done = 1'b1;
            pix_left_d       = pix_cnt_q;
          end
        end
      end else begin
        // Gather a partial pixel
        accum_d    = merged[23:0];
        byte_idx_d = byte_idx_q + 2'd1;
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBytesPerPixel: bpp_d = cfg_data_i[BppWidth-1:0];
        CfgPixelCount: begin
          pix_cnt_d  = cfg_data_i[PixCntWidth-1:0];
          pix_left_d = cfg_data_i[PixCntWidth-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q      <= BppReset;
      pix_cnt_q  <= PixCntReset;
      pix_left_q <= PixCntReset;
      in_body_q  <= 1'b0;
      repeat_q   <= 1'b0;
      pkt_left_q <= '0;
      byte_idx_q <= '0;
      accum_q    <= '0;
      err_q      <= 1'b0;
    end else begin
      bpp_q      <= bpp_d;
      pix_cnt_q  <= pix_cnt_d;
      pix_left_q <= pix_left_d;
      in_body_q  <= in_body_d;
      repeat_q   <= repeat_d;
      pkt_left_q <= pkt_left_d;
      byte_idx_q <= byte_idx_d;
      accum_q    <= accum_d;
      err_q      <= err_d;
    end
  end

endmodule

FILE: hdl/trd_out_buf.sv
`timescale 1ns / 1ps

module trd_out_buf
  import trd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop         = main_vld_q && !out_stall_i;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;
  assign full_o      = skid_vld_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        // Advance the held beat, park any new one
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_vld_d = push_i;
        skid_d     = push_data_i;
      end else begin
        main_vld_d = push_i;
        main_d     = push_data_i;
      end
    end else if (push_i) begin
      skid_vld_d = 1'b1;
      skid_d     = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

FILE: hdl/tga_rle_packet_decoder.sv
`timescale 1ns / 1ps
// A result beat is registered in the output buffer before it shows on the output.
// Throughput: one stream byte per cycle while the skid entry is free; the byte parser updates its state in one pass.
// A two-entry output buffer lets input run on while one result beat waits downstream.
// Reset (rst_ni low, asynchronous): pixel size 1, pixel count 1, expect a header,
// error cleared, output buffer empty.

module tga_rle_packet_decoder
  import trd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Compressed byte stream
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  // Decoded pixel runs
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [31:0]            pixel_value_o,
  output logic [RunWidth-1:0]    run_length_o,
  output logic                   image_done_o,
  output logic                   format_error_o,
  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);

  logic beat;
  logic res_valid;
  logic buf_full;
  res_t res;
  res_t out_res;

  // A byte is taken whenever the skid entry is free, even while the
  // output beat is stalled: each byte makes at most one result.
  assign in_stall_o = buf_full;
  assign beat       = in_valid_i && !buf_full;

  // Parse headers, gather pixel bytes, track pixels still due and the
  // sticky format error. Configuration writes land here too.
  trd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold results: output register plus one skid entry
  trd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign pixel_value_o  = out_res.pixel_value;
  assign run_length_o   = out_res.run_length;
  assign image_done_o   = out_res.image_done;
  assign format_error_o = out_res.format_error;

endmodule

FILE: tb/sv/tb_tga_rle_packet_decoder.sv
`timescale 1ns / 1ps

module tb_tga_rle_packet_decoder;
  import trd_pkg::*;

  localparam int unsigned GapMax      = 6;
  localparam int unsigned SettleCycles = 3;    // parser latency plus margin
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned StallLimit  = 1000;  // cycles with no input beat or write
  localparam int unsigned RandomBytes = 1550;
  localparam int unsigned PixCountMax = 1073676289;

  // Scoreboard: tracks the decoder state as bytes are accepted and holds the
  // pixel runs that must come out, oldest first.
  class run_scoreboard;
    logic [BppWidth-1:0]    bpp_reg;
    logic [PixCntWidth-1:0] pix_count_reg;
    bit                     in_body;
    bit                     rep_pkt;
    logic [7:0]             left;
    logic [1:0]             byte_idx;
    logic [23:0]            accum;
    logic [30:0]            remaining;
    bit                     halted;
    res_t                   pending_runs[$];
    int unsigned            images_closed;
    int unsigned            mismatches;

    function new();
      bpp_reg       = BppReset;
      pix_count_reg = PixCntReset;
      in_body       = 1'b0;
      rep_pkt       = 1'b0;
      left          = '0;
      byte_idx      = '0;
      accum         = '0;
      remaining     = 31'(PixCntReset);
      halted        = 1'b0;
      images_closed = 0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
      if (idx == CfgBytesPerPixel) begin
        bpp_reg = value[BppWidth-1:0];
      end else begin
        // Reload the pixel budget at once; a packet in flight carries on
        pix_count_reg = value[PixCntWidth-1:0];
        remaining     = 31'(pix_count_reg);
      end
    endfunction

    // Advance the decoder state by one accepted byte and queue any run it closes
    function void note_byte(logic [7:0] b);
      int unsigned size;
      logic [7:0]  cnt;
      logic [31:0] value;
      res_t        run;
      size = (bpp_reg == 0) ? 1 : (bpp_reg > BppMax) ? 4 : int'(bpp_reg);
      if (halted) return;
      if (!in_body) begin
        cnt = 8'(b[6:0]) + 8'd1;
        if (31'(cnt) > remaining) begin
          // Packet overruns the image: flag it once and go dead until reset
          halted = 1'b1;
          run = '0;
          run.format_error = 1'b1;
          pending_runs.push_back(run);
          return;
        end
        remaining = remaining - 31'(cnt);
        rep_pkt   = b[7];
        left      = cnt;
        in_body   = 1'b1;
        byte_idx  = '0;
        accum     = '0;
        return;
      end
      if (32'(byte_idx) + 1 >= size) begin
        // Last byte of the pixel; a lowered size finishes a part-read pixel here
        value = 32'(accum) | (32'(b) << (8 * byte_idx));
        run = '0;
        run.pixel_value = value;
        if (rep_pkt) begin
          run.run_length = left;
          left = '0;
        end else begin
          run.run_length = 8'd1;
          left = left - 8'd1;
        end
        byte_idx = '0;
        accum    = '0;
        if (left == 0) begin
          in_body = 1'b0;
          if (remaining == 0) begin
            run.image_done = 1'b1;
            remaining = 31'(pix_count_reg);
            images_closed++;
          end
        end
        pending_runs.push_back(run);
      end else begin
        accum    = 24'(32'(accum) | (32'(b) << (8 * byte_idx)));
        byte_idx = byte_idx + 2'd1;
      end
    endfunction

    function void check_run(res_t got);
      res_t want;
      if (pending_runs.size() == 0) begin
        $display("%0t: run beat with none due: pixel_value %h run_length %0d done %b err %b",
                 $time, got.pixel_value, got.run_length, got.image_done, got.format_error);
        mismatches++;
        return;
      end
      want = pending_runs.pop_front();
      if (got.pixel_value !== want.pixel_value) begin
        $display("%0t: pixel_value expected %h, got %h", $time, want.pixel_value,
                 got.pixel_value);
        mismatches++;
      end
      if (got.run_length !== want.run_length) begin
        $display("%0t: run_length expected %0d, got %0d", $time, want.run_length,
                 got.run_length);
        mismatches++;
      end
      if (got.image_done !== want.image_done) begin
        $display("%0t: image_done expected %b, got %b", $time, want.image_done,
                 got.image_done);
        mismatches++;
      end
      if (got.format_error !== want.format_error) begin
        $display("%0t: format_error expected %b, got %b", $time, want.format_error,
                 got.format_error);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte   = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [31:0]            pixel_value;
  logic [RunWidth-1:0]    run_length;
  logic                   image_done;
  logic                   format_error;
  logic                   cfg_we      = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx     = '0;
  logic [CfgWidth-1:0]    cfg_data    = '0;

  run_scoreboard board;
  bit            quiet      = 1'b0;   // stretch with no gaps on either side
  int unsigned   bytes_sent = 0;
  int unsigned   idle_cycles;

  tga_rle_packet_decoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_value_o  (pixel_value),
    .run_length_o   (run_length),
    .image_done_o   (image_done),
    .format_error_o (format_error),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one byte after a random gap and hold it until the decoder takes the beat.
  // Valid is left high afterwards, so back-to-back beats keep it high with no drop.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, GapMax);
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_byte(b);
    bytes_sent++;
  endtask

  // Drop valid, drain every due run, then let the parser settle: a header or a
  // part pixel leaves no result to wait on.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (board.pending_runs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.write_reg(idx, value);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // Next byte of a well-formed stream: a header that fits the pixels still due,
  // or a pixel byte biased towards the extremes.
  function automatic logic [7:0] pick_byte();
    int unsigned limit;
    int unsigned cnt;
    logic        kind;
    if (!board.in_body) begin
      limit = (board.remaining > MaxPacket) ? MaxPacket : int'(board.remaining);
      kind  = 1'($urandom_range(0, 1));
      // Keep most literal packets short so wide pixels do not eat the byte budget
      if (!kind && limit > 8 && $urandom_range(0, 7) != 0) limit = 8;
      case ($urandom_range(0, 9))
        0:       cnt = limit;
        1:       cnt = 1;
        default: cnt = $urandom_range(1, limit);
      endcase
      return {kind, 7'(cnt - 1)};
    end
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: hold stall for a random number of cycles, then take one beat
  initial begin
    int unsigned hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, GapMax);
      if (hold != 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Check every result beat against the oldest run due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_run({pixel_value, run_length, image_done, format_error});
  end

  // Watchdog: give up when no byte or write goes in for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned budget;
    int unsigned sent_in_phase;
    int unsigned closed;
    int unsigned pc_pick;
    int unsigned lead;
    int unsigned cnt;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: reset sizes, a literal and a repeat packet of one pixel each
    send_byte(8'h00);
    send_byte(8'ha5);
    send_byte(8'h80);
    send_byte(8'h5a);

    // Widest pixel, largest image the bench uses, longest repeat run
    wait_idle();
    cfg_write(CfgBytesPerPixel, CfgWidth'(4));
    cfg_write(CfgPixelCount, CfgWidth'(PixCountMax));
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'hfe);

    // Lower the size while a pixel is half read: the next byte closes it
    send_byte(8'h01);
    send_byte(8'h11);
    send_byte(8'h22);
    wait_idle();
    cfg_write(CfgBytesPerPixel, CfgWidth'(1));
    send_byte(8'h33);
    // Reload the pixel budget inside a packet; the packet still finishes
    wait_idle();
    cfg_write(CfgPixelCount, CfgWidth'(1));
    send_byte(8'h44);
    send_byte(8'h00);
    send_byte(8'hc3);

    // Size zero acts as one byte
    wait_idle();
    cfg_write(CfgBytesPerPixel, CfgWidth'(0));
    cfg_write(CfgPixelCount, CfgWidth'(2));
    send_byte(8'h81);
    send_byte(8'h7e);

    // Size above four acts as four; repeat packet covers the whole image
    wait_idle();
    cfg_write(CfgBytesPerPixel, CfgWidth'(7));
    cfg_write(CfgPixelCount, CfgWidth'(MaxPacket));
    send_byte(8'hff);
    send_byte(8'hc0);
    send_byte(8'h3c);
    send_byte(8'h0f);
    send_byte(8'hf0);

    // Random phases: mostly whole images with random content; some phases stop
    // part way so the next settings land mid-packet or mid-pixel
    lead = bytes_sent;
    while (bytes_sent < lead + RandomBytes) begin
      wait_idle();
      quiet = ($urandom_range(0, 4) == 0);
      cfg_write(CfgBytesPerPixel, CfgWidth'($urandom_range(0, 7)));
      budget  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 400;
      pc_pick = $urandom_range(0, 9);
      if (pc_pick == 0) begin
        cfg_write(CfgPixelCount, CfgWidth'($urandom_range(1, PixCountMax)));
        budget = $urandom_range(10, 60);
      end else if (pc_pick == 1) begin
        cfg_write(CfgPixelCount, CfgWidth'(1));
      end else if (pc_pick > 2) begin
        cfg_write(CfgPixelCount, CfgWidth'($urandom_range(2, 300)));
      end
      closed = board.images_closed;
      sent_in_phase = 0;
      while (sent_in_phase < budget && board.images_closed == closed) begin
        send_byte(pick_byte());
        sent_in_phase++;
      end
    end

    // Overrun: the error sticks until reset, so it closes the run
    wait_idle();
    quiet = 1'b0;
    if ($urandom_range(0, 1) == 0) begin
      // Zero pixel count: any header overruns
      cfg_write(CfgPixelCount, CfgWidth'(0));
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      cfg_write(CfgBytesPerPixel, CfgWidth'($urandom_range(0, 7)));
      cfg_write(CfgPixelCount, CfgWidth'($urandom_range(1, 100)));
      repeat ($urandom_range(0, 30)) send_byte(pick_byte());
      while (board.in_body) send_byte(pick_byte());
      cnt = $urandom_range(board.remaining + 1, MaxPacket);
      send_byte({1'($urandom_range(0, 1)), 7'(cnt - 1)});
    end
    // Bytes after the error must vanish without a result
    repeat (12) send_byte(8'($urandom_range(0, 255)));

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
